/* hdl/nsst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nsst_pkg;

  localparam int PHASE_BITS = 16;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_TPU_X = 2'd1;
  localparam logic [1:0] REG_TPU_Y = 2'd2;
  localparam logic [1:0] REG_TPU_Z = 2'd3;

  localparam logic [2:0] MODE_P = 3'd0;
  localparam logic [2:0] MODE_D = 3'd1;
  localparam logic [2:0] MODE_GYROID = 3'd2;
  localparam logic [2:0] MODE_IWP_IN = 3'd3;
  localparam logic [2:0] MODE_IWP_OUT = 3'd4;

  localparam logic [31:0] TPU_RESET = 32'd65536;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // Unsigned quotient by restoring shift and subtract; den stays small.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    int b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine sample j of a table with 2^qbits steps per quarter,
  // Taylor series in Q2.62, rounded half up and saturated to sbits-1 bits.
  function automatic logic [31:0] quarter_wave_entry(input int j, input int qbits,
                                                    input int sbits);
    logic [63:0] lowmask;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] maxv;
    logic [63:0] div;
    logic [127:0] prod;
    int n;
    lowmask = (64'd1 << qbits) - 64'd1;
    x = (HALF_PI_Q62 >> qbits) * 64'(j) + (((HALF_PI_Q62 & lowmask) * 64'(j)) >> qbits);
    prod = {64'd0, x} * {64'd0, x};
    x2 = prod[125:62];
    term = x;
    sum = x;
    for (n = 1; n <= 24; n++) begin
      prod = {64'd0, term} * {64'd0, x2};
      div = 64'(2 * n) * 64'(2 * n + 1);
      term = udiv64(prod[125:62], div);
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + (64'd1 << (62 - sbits))) >> (63 - sbits);
    maxv = (64'd1 << (sbits - 1)) - 64'd1;
    if (v > maxv) begin
      v = maxv;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/nodal_surface_side_test.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one point per cycle while res_ready holds high; five
// registered stages (phase multiply, sine lookup, pair products, triple
// products and sums, compare). Stalls only back up through stages that
// are full; bubbles collapse.
// Reset (rst, synchronous): all stage valid bits cleared, surface_mode = 0,
// turns_per_unit_x/y/z = 65536. The sine table is constant logic.
module nodal_surface_side_test #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [nsst_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [nsst_pkg::DATA_BITS-1:0] pwdata,
  output logic      [nsst_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready,
  input  wire logic                           pt_valid,
  output logic                                pt_ready,
  input  wire logic signed [31:0]             pos_x,
  input  wire logic signed [31:0]             pos_y,
  input  wire logic signed [31:0]             pos_z,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic                                overlaps
);
  import nsst_pkg::*;

  localparam int TA = TABLE_ADDR_BITS;
  localparam int QB = TABLE_ADDR_BITS - 2;
  localparam int QUARTER = 1 << QB;
  localparam int SW = SAMPLE_BITS;
  localparam int PW = 2 * SAMPLE_BITS;
  localparam int TW = 3 * SAMPLE_BITS;
  localparam int DW = 3 * SAMPLE_BITS + 2;
  localparam int GW = 2 * SAMPLE_BITS + 2;
  localparam int IW = 2 * SAMPLE_BITS + 4;
  localparam int CW = SAMPLE_BITS + 2;

  logic [2:0]  surface_mode;
  logic [31:0] turns_per_unit_x;
  logic [31:0] turns_per_unit_y;
  logic [31:0] turns_per_unit_z;

  logic cfg_write;
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_mode <= MODE_P;
      turns_per_unit_x <= TPU_RESET;
      turns_per_unit_y <= TPU_RESET;
      turns_per_unit_z <= TPU_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MODE:  surface_mode <= pwdata[2:0];
        REG_TPU_X: turns_per_unit_x <= pwdata;
        REG_TPU_Y: turns_per_unit_y <= pwdata;
        REG_TPU_Z: turns_per_unit_z <= pwdata;
        default:   surface_mode <= surface_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:  prdata = {29'd0, surface_mode};
      REG_TPU_X: prdata = turns_per_unit_x;
      REG_TPU_Y: prdata = turns_per_unit_y;
      REG_TPU_Z: prdata = turns_per_unit_z;
      default:   prdata = '0;
    endcase
  end

  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s4_valid;
  logic s1_en;
  logic s2_en;
  logic s3_en;
  logic s4_en;
  logic res_en;

  assign res_en = !res_valid || res_ready;
  assign s4_en = !s4_valid || res_en;
  assign s3_en = !s3_valid || s4_en;
  assign s2_en = !s2_valid || s3_en;
  assign s1_en = !s1_valid || s2_en;
  assign pt_ready = s1_en;

  logic [31:0] prod_x;
  logic [31:0] prod_y;
  logic [31:0] prod_z;
  assign prod_x = $unsigned(pos_x) * turns_per_unit_x;
  assign prod_y = $unsigned(pos_y) * turns_per_unit_y;
  assign prod_z = $unsigned(pos_z) * turns_per_unit_z;

  logic [PHASE_BITS-1:0] s1_px;
  logic [PHASE_BITS-1:0] s1_py;
  logic [PHASE_BITS-1:0] s1_pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_px <= prod_x[31:16];
      s1_py <= prod_y[31:16];
      s1_pz <= prod_z[31:16];
    end
  end

  logic [SW-2:0] qw [QUARTER+1];

  for (genvar j = 0; j <= QUARTER; j++) begin : g_qw
    localparam logic [31:0] QW_J = quarter_wave_entry(j, QB, SW);
    assign qw[j] = QW_J[SW-2:0];
  end

  logic [PHASE_BITS-1:0] s1_dx;
  logic [PHASE_BITS-1:0] s1_dy;
  logic [PHASE_BITS-1:0] s1_dz;
  assign s1_dx = {s1_px[PHASE_BITS-2:0], 1'b0};
  assign s1_dy = {s1_py[PHASE_BITS-2:0], 1'b0};
  assign s1_dz = {s1_pz[PHASE_BITS-2:0], 1'b0};

  logic [TA-1:0] tab_addr [9];
  logic signed [SW-1:0] tab_val [9];

  assign tab_addr[0] = s1_px[PHASE_BITS-1 -: TA];
  assign tab_addr[1] = s1_py[PHASE_BITS-1 -: TA];
  assign tab_addr[2] = s1_pz[PHASE_BITS-1 -: TA];
  assign tab_addr[3] = s1_px[PHASE_BITS-1 -: TA] + TA'(QUARTER);
  assign tab_addr[4] = s1_py[PHASE_BITS-1 -: TA] + TA'(QUARTER);
  assign tab_addr[5] = s1_pz[PHASE_BITS-1 -: TA] + TA'(QUARTER);
  assign tab_addr[6] = s1_dx[PHASE_BITS-1 -: TA] + TA'(QUARTER);
  assign tab_addr[7] = s1_dy[PHASE_BITS-1 -: TA] + TA'(QUARTER);
  assign tab_addr[8] = s1_dz[PHASE_BITS-1 -: TA] + TA'(QUARTER);

  for (genvar g = 0; g < 9; g++) begin : g_lookup
    logic [1:0]    quad;
    logic [QB-1:0] low;
    logic [QB:0]   idx;
    logic [SW-1:0] mag;
    assign quad = tab_addr[g][TA-1 -: 2];
    assign low = tab_addr[g][QB-1:0];
    assign idx = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, low}) : {1'b0, low};
    assign mag = {1'b0, qw[idx]};
    assign tab_val[g] = quad[1] ? -$signed(mag) : $signed(mag);
  end

  logic signed [SW-1:0] s2_sx;
  logic signed [SW-1:0] s2_sy;
  logic signed [SW-1:0] s2_sz;
  logic signed [SW-1:0] s2_cx;
  logic signed [SW-1:0] s2_cy;
  logic signed [SW-1:0] s2_cz;
  logic signed [SW-1:0] s2_dcx;
  logic signed [SW-1:0] s2_dcy;
  logic signed [SW-1:0] s2_dcz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_sx <= tab_val[0];
      s2_sy <= tab_val[1];
      s2_sz <= tab_val[2];
      s2_cx <= tab_val[3];
      s2_cy <= tab_val[4];
      s2_cz <= tab_val[5];
      s2_dcx <= tab_val[6];
      s2_dcy <= tab_val[7];
      s2_dcz <= tab_val[8];
    end
  end

  logic signed [PW-1:0] s3_sxsy;
  logic signed [PW-1:0] s3_sxcy;
  logic signed [PW-1:0] s3_cxsy;
  logic signed [PW-1:0] s3_cxcy;
  logic signed [PW-1:0] s3_cysz;
  logic signed [PW-1:0] s3_czsx;
  logic signed [PW-1:0] s3_cycz;
  logic signed [PW-1:0] s3_czcx;
  logic signed [SW-1:0] s3_sz;
  logic signed [SW-1:0] s3_cz;
  logic signed [CW-1:0] s3_csum;
  logic signed [CW-1:0] s3_dsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_sxsy <= s2_sx * s2_sy;
      s3_sxcy <= s2_sx * s2_cy;
      s3_cxsy <= s2_cx * s2_sy;
      s3_cxcy <= s2_cx * s2_cy;
      s3_cysz <= s2_cy * s2_sz;
      s3_czsx <= s2_cz * s2_sx;
      s3_cycz <= s2_cy * s2_cz;
      s3_czcx <= s2_cz * s2_cx;
      s3_sz <= s2_sz;
      s3_cz <= s2_cz;
      s3_csum <= CW'(s2_cx) + CW'(s2_cy) + CW'(s2_cz);
      s3_dsum <= CW'(s2_dcx) + CW'(s2_dcy) + CW'(s2_dcz);
    end
  end

  logic signed [TW-1:0] s4_t0;
  logic signed [TW-1:0] s4_t1;
  logic signed [TW-1:0] s4_t2;
  logic signed [TW-1:0] s4_t3;
  logic signed [GW-1:0] s4_gyr;
  logic signed [IW-1:0] s4_iwp;
  logic signed [CW-1:0] s4_csum;
  logic signed [IW-1:0] iwp_pairs;

  assign iwp_pairs = IW'(s3_cxcy) + IW'(s3_cycz) + IW'(s3_czcx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_t0 <= s3_sxsy * s3_sz;
      s4_t1 <= s3_sxcy * s3_cz;
      s4_t2 <= s3_cxsy * s3_cz;
      s4_t3 <= s3_cxcy * s3_sz;
      s4_gyr <= GW'(s3_cxsy) + GW'(s3_cysz) + GW'(s3_czsx);
      s4_iwp <= (iwp_pairs <<< 1) - IW'(s3_dsum);
      s4_csum <= s3_csum;
    end
  end

  logic signed [DW-1:0] d_val;
  logic                 hit;

  assign d_val = DW'(s4_t0) + DW'(s4_t1) + DW'(s4_t2) + DW'(s4_t3);

  always_comb begin
    case (surface_mode)
      MODE_P:       hit = s4_csum[CW-1];
      MODE_D:       hit = d_val[DW-1];
      MODE_GYROID:  hit = s4_gyr[GW-1];
      MODE_IWP_IN:  hit = s4_iwp[IW-1];
      MODE_IWP_OUT: hit = !s4_iwp[IW-1] && (s4_iwp != '0);
      default:      hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_en) begin
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      overlaps <= hit;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_ready |=> s1_valid)
    else $error("accepted beat did not enter the first stage");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !pt_ready |-> s1_valid && s2_valid && s3_valid && s4_valid && res_valid)
    else $error("input stalled with an empty stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !s4_valid |=> !res_valid)
    else $error("result beat repeated");

  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && $past(res_en) && surface_mode > MODE_IWP_OUT |-> !overlaps)
    else $error("unused mode flagged a hit");
`endif

endmodule

`default_nettype wire
